// File: rtl/ppts_pkg.sv
// Shared types, constants and helpers for the perspective projection pipeline.
`default_nettype none

package ppts_pkg;

	// Word and fixed-point layout
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned PROD_SHIFT = 16;
	localparam int unsigned PROD_W     = 2 * WORD_W - PROD_SHIFT;
	localparam int unsigned SUM_W      = PROD_W + 2;
	localparam int unsigned CFG_W      = 64;
	localparam int unsigned ROW_WORDS  = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned VP_W       = 14;

	// Pixel mapping: scale by 32768 before the divide
	localparam int unsigned PIX_SHIFT  = 15;
	localparam int unsigned MAG_W      = WORD_W + VP_W;
	localparam int unsigned DIV_QBITS  = WORD_W;
	localparam int unsigned OVF_SHIFT  = DIV_QBITS - PIX_SHIFT;
	localparam int unsigned CMP_W      = WORD_W + OVF_SHIFT;
	localparam int unsigned DIV_STEPS  = 2;
	localparam int unsigned DIV_STAGES = DIV_QBITS / DIV_STEPS;
	localparam int unsigned RES_W      = WORD_W + 3;

	// Behind-the-viewer path
	localparam int unsigned CLAMP_W    = 16;
	localparam int unsigned SCALE_W    = 18;
	localparam int unsigned BEHIND_W   = CLAMP_W + SCALE_W;
	localparam logic signed [WORD_W-1:0]  BEHIND_W_RAW = 32'sd66;
	localparam logic signed [CLAMP_W-1:0] BEHIND_CLAMP = 16'sd21475;
	localparam logic signed [SCALE_W-1:0] BEHIND_SCALE = 18'sd100000;

	// Register file reset values
	localparam logic [VP_W-1:0] VP_WIDTH_RST  = 14'd1920;
	localparam logic [VP_W-1:0] VP_HEIGHT_RST = 14'd1080;

	// Registers from input to output: clip (2), prep (2), divider, output
	localparam int unsigned PIPE_DEPTH = 4 + (DIV_STAGES + 1) + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X_FIRST  = 3'd0,
		REG_ROW_X_SECOND = 3'd1,
		REG_ROW_Y_FIRST  = 3'd2,
		REG_ROW_Y_SECOND = 3'd3,
		REG_ROW_W_FIRST  = 3'd4,
		REG_ROW_W_SECOND = 3'd5,
		REG_VP_WIDTH     = 3'd6,
		REG_VP_HEIGHT    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] world_x;
		logic signed [WORD_W-1:0] world_y;
		logic signed [WORD_W-1:0] world_z;
	} point_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pixel_x;
		logic signed [WORD_W-1:0] pixel_y;
		logic                     in_front;
	} screen_t;

	typedef logic [ROW_WORDS-1:0][CFG_W-1:0] mat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] cx;
		logic signed [WORD_W-1:0] cy;
		logic signed [WORD_W-1:0] cw;
	} clip_t;

	typedef struct packed {
		logic                       behind;
		logic signed [BEHIND_W-1:0] bx;
		logic signed [BEHIND_W-1:0] by;
	} tag_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
	} num_t;

	typedef struct packed {
		num_t              x;
		num_t              y;
		logic [WORD_W-1:0] cw;
		tag_t              tag;
	} div_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] quo;
		logic              ovf;
		logic              neg;
	} lane_t;

	typedef struct packed {
		logic [WORD_W-1:0] quo;
		logic              ovf;
		logic              neg;
	} quot_t;

	typedef struct packed {
		quot_t x;
		quot_t y;
		tag_t  tag;
	} div_out_t;

	// Saturate a sign-extended value to a signed 32-bit word
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic hi_any;
		logic hi_all;
		hi_any = |v[SUM_W-2:WORD_W-1];
		hi_all = &v[SUM_W-2:WORD_W-1];
		if (!v[SUM_W-1] && hi_any) begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v[SUM_W-1] && !hi_all) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/ppts_clip.sv
// Clip-space transform: three matrix rows dotted with the point, two pipeline stages.
`default_nettype none

module ppts_clip (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	input  wire ppts_pkg::point_t point,
	input  wire ppts_pkg::mat_t   rows,
	input  wire logic            rdy_nxt,
	output logic                 rdy,
	output logic                 vld_out,
	output ppts_pkg::clip_t      clip
);

	logic signed [ppts_pkg::WORD_W-1:0]   coord [3];
	logic signed [2*ppts_pkg::WORD_W-1:0] prod [3][3];
	logic signed [ppts_pkg::PROD_W-1:0]   prod_s1 [3][3];
	logic signed [ppts_pkg::SUM_W-1:0]    sum [3];
	logic signed [ppts_pkg::WORD_W-1:0]   trans [3];
	logic                                 vld_s1;
	logic                                 vld_s2;
	logic                                 rdy_s1;
	logic                                 rdy_s2;
	ppts_pkg::clip_t                      clip_s2;

	assign coord[0] = point.world_x;
	assign coord[1] = point.world_y;
	assign coord[2] = point.world_z;

	// Advance a stage when it is empty or the next one takes its request
	assign rdy_s2 = !vld_s2 || rdy_nxt;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	// Form the nine matrix-by-coordinate products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod[r][c] = $signed(rows[2 * r + (c >> 1)][ppts_pkg::WORD_W * (c & 1) +:
					ppts_pkg::WORD_W]) * coord[c];
			end
		end
	end

	// Hold products floored to Q16.16
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= prod[r][c][2*ppts_pkg::WORD_W-1:ppts_pkg::PROD_SHIFT];
				end
			end
		end
	end

	// Add the translation column and the three products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			trans[r] = $signed(rows[2 * r + 1][2*ppts_pkg::WORD_W-1:ppts_pkg::WORD_W]);
			sum[r]   = ppts_pkg::SUM_W'(prod_s1[r][0]) + ppts_pkg::SUM_W'(prod_s1[r][1]) +
				ppts_pkg::SUM_W'(prod_s1[r][2]) + ppts_pkg::SUM_W'(trans[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			clip_s2.cx <= ppts_pkg::sat32(sum[0]);
			clip_s2.cy <= ppts_pkg::sat32(sum[1]);
			clip_s2.cw <= ppts_pkg::sat32(sum[2]);
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign rdy     = rdy_s1;
	assign vld_out = vld_s2;
	assign clip    = clip_s2;

endmodule

`default_nettype wire

// File: rtl/ppts_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, two quotient bits per stage.
`default_nettype none

module ppts_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid,
	input  wire ppts_pkg::div_in_t din,
	input  wire logic              rdy_nxt,
	output logic                   rdy,
	output logic                   vld_out,
	output ppts_pkg::div_out_t     dout
);

	localparam int unsigned N = ppts_pkg::DIV_STAGES;
	localparam int unsigned W = ppts_pkg::WORD_W;

	logic                vld_s [N+1];
	logic                rdy_s [N+2];
	ppts_pkg::lane_t     lane_s [N+1][2];
	logic [W-1:0]        cw_s [N+1];
	ppts_pkg::tag_t      tag_s [N+1];

	// Load the upper dividend bits as remainder; flag quotients of 2^32 and up
	function automatic ppts_pkg::lane_t lane_init(input ppts_pkg::num_t n, input logic [W-1:0] cw);
		ppts_pkg::lane_t l;
		l.rem = W'(n.mag >> ppts_pkg::OVF_SHIFT);
		l.lo  = {n.mag[ppts_pkg::OVF_SHIFT-1:0], {ppts_pkg::PIX_SHIFT{1'b0}}};
		l.quo = '0;
		l.ovf = ppts_pkg::CMP_W'(n.mag) >= {cw, {ppts_pkg::OVF_SHIFT{1'b0}}};
		l.neg = n.neg;
		return l;
	endfunction

	// Shift in dividend bits, subtract where the divisor fits
	function automatic ppts_pkg::lane_t lane_step(input ppts_pkg::lane_t l, input logic [W-1:0] cw);
		ppts_pkg::lane_t o;
		logic [W-1:0]    r2;
		logic [W:0]      diff;
		o = l;
		for (int j = 0; j < ppts_pkg::DIV_STEPS; j++) begin
			r2    = {o.rem[W-2:0], o.lo[W-1]};
			diff  = {1'b0, r2} - {1'b0, cw};
			o.lo  = {o.lo[W-2:0], 1'b0};
			o.rem = diff[W] ? r2 : diff[W-1:0];
			o.quo = {o.quo[W-2:0], !diff[W]};
		end
		return o;
	endfunction

	// Ready ripples back from the output side
	assign rdy_s[N+1] = rdy_nxt;
	for (genvar k = 0; k <= N; k++) begin : g_rdy
		assign rdy_s[k] = !vld_s[k] || rdy_s[k+1];
	end

	// Setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy_s[0]) begin
			vld_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[0]) begin
			lane_s[0][0] <= lane_init(din.x, din.cw);
			lane_s[0][1] <= lane_init(din.y, din.cw);
			cw_s[0]      <= din.cw;
			tag_s[0]     <= din.tag;
		end
	end

	// Iteration stages
	for (genvar k = 1; k <= N; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k]) begin
				lane_s[k][0] <= lane_step(lane_s[k-1][0], cw_s[k-1]);
				lane_s[k][1] <= lane_step(lane_s[k-1][1], cw_s[k-1]);
				cw_s[k]      <= cw_s[k-1];
				tag_s[k]     <= tag_s[k-1];
			end
		end
	end

	assign rdy        = rdy_s[0];
	assign vld_out    = vld_s[N];
	assign dout.x.quo = lane_s[N][0].quo;
	assign dout.x.ovf = lane_s[N][0].ovf;
	assign dout.x.neg = lane_s[N][0].neg;
	assign dout.y.quo = lane_s[N][1].quo;
	assign dout.y.ovf = lane_s[N][1].ovf;
	assign dout.y.neg = lane_s[N][1].neg;
	assign dout.tag   = tag_s[N];

endmodule

`default_nettype wire

// File: rtl/perspective_project_to_screen_top.sv
// Top level: register file, clip transform, prep stages, divider and output register.
// Throughput: one point per cycle while the output is not stalled; the 17-stage divider
// pipeline and the clip multipliers each take a new request every cycle unless stalled.
// Input stalls only when all 22 stages hold requests and the output is stalled.
// Reset clears all valid bits and the matrix; viewport resets to 1920 x 1080.
`default_nettype none

module perspective_project_to_screen_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             point_valid,
	output logic                                  point_stall,
	input  wire ppts_pkg::point_t                 point,
	output logic                                  screen_valid,
	input  wire logic                             screen_stall,
	output ppts_pkg::screen_t                     screen,
	input  wire logic                             cfg_we,
	input  wire logic [ppts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ppts_pkg::CFG_W-1:0]       cfg_data
);

	localparam int unsigned W = ppts_pkg::WORD_W;

	ppts_pkg::mat_t             rows_q;
	logic [ppts_pkg::VP_W-1:0]  vp_w_q;
	logic [ppts_pkg::VP_W-1:0]  vp_h_q;

	logic                       rdy_s1;
	logic                       vld_clip;
	ppts_pkg::clip_t            clip;

	logic                       vld_s3;
	logic                       rdy_s3;
	logic                       behind_s3;
	logic [W-1:0]               abs_x_s3;
	logic [W-1:0]               abs_y_s3;
	logic                       neg_x_s3;
	logic                       neg_y_s3;
	logic [W-1:0]               cw_s3;
	logic signed [ppts_pkg::CLAMP_W-1:0] clamp_x_s3;
	logic signed [ppts_pkg::CLAMP_W-1:0] clamp_y_s3;

	logic                       vld_s4;
	logic                       rdy_s4;
	ppts_pkg::div_in_t          din_s4;

	logic                       rdy_div;
	logic                       vld_div;
	ppts_pkg::div_out_t         dout;

	logic                       vld_s22;
	logic                       rdy_s22;
	ppts_pkg::screen_t          screen_s22;

	logic signed [ppts_pkg::RES_W-1:0] base_x;
	logic signed [ppts_pkg::RES_W-1:0] base_y;
	logic signed [ppts_pkg::RES_W-1:0] res_x;
	logic signed [ppts_pkg::RES_W-1:0] res_y;

	function automatic logic [W-1:0] mag32(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	// Limit clip values so the scaled product stays within 34 bits
	function automatic logic signed [ppts_pkg::CLAMP_W-1:0] clamp16(input logic signed [W-1:0] v);
		if (v > ppts_pkg::BEHIND_CLAMP) begin
			return ppts_pkg::BEHIND_CLAMP;
		end else if (v < -ppts_pkg::BEHIND_CLAMP) begin
			return -ppts_pkg::BEHIND_CLAMP;
		end
		return v[ppts_pkg::CLAMP_W-1:0];
	endfunction

	// Apply the quotient sign; an overflowed quotient counts as 2^32
	function automatic logic signed [ppts_pkg::RES_W-1:0] signed_quot(input ppts_pkg::quot_t q);
		logic [ppts_pkg::RES_W-1:0] mag;
		mag = q.ovf ? (ppts_pkg::RES_W'(1) << ppts_pkg::DIV_QBITS) : ppts_pkg::RES_W'(q.quo);
		return q.neg ? -mag : mag;
	endfunction

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			vp_w_q <= ppts_pkg::VP_WIDTH_RST;
			vp_h_q <= ppts_pkg::VP_HEIGHT_RST;
		end else if (cfg_we) begin
			case (ppts_pkg::cfg_reg_t'(cfg_index))
				ppts_pkg::REG_ROW_X_FIRST, ppts_pkg::REG_ROW_X_SECOND,
				ppts_pkg::REG_ROW_Y_FIRST, ppts_pkg::REG_ROW_Y_SECOND,
				ppts_pkg::REG_ROW_W_FIRST, ppts_pkg::REG_ROW_W_SECOND: begin
					rows_q[cfg_index] <= cfg_data;
				end
				ppts_pkg::REG_VP_WIDTH: begin
					vp_w_q <= cfg_data[ppts_pkg::VP_W-1:0];
				end
				ppts_pkg::REG_VP_HEIGHT: begin
					vp_h_q <= cfg_data[ppts_pkg::VP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clip transform, stages 1 and 2
	ppts_clip u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (point_valid),
		.point   (point),
		.rows    (rows_q),
		.rdy_nxt (rdy_s3),
		.rdy     (rdy_s1),
		.vld_out (vld_clip),
		.clip    (clip)
	);

	assign point_stall = !rdy_s1;

	// Ready chain through the prep stages
	assign rdy_s4 = !vld_s4 || rdy_div;
	assign rdy_s3 = !vld_s3 || rdy_s4;

	// Stage 3: split sign and magnitude, clamp for the behind path
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			behind_s3  <= clip.cw < ppts_pkg::BEHIND_W_RAW;
			abs_x_s3   <= mag32(clip.cx);
			abs_y_s3   <= mag32(clip.cy);
			neg_x_s3   <= clip.cx[W-1];
			neg_y_s3   <= clip.cy[W-1];
			cw_s3      <= clip.cw;
			clamp_x_s3 <= clamp16(clip.cx);
			clamp_y_s3 <= clamp16(clip.cy);
		end
	end

	// Stage 4: scale by viewport size and by the behind factor
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			din_s4.x.mag   <= ppts_pkg::MAG_W'(abs_x_s3) * ppts_pkg::MAG_W'(vp_w_q);
			din_s4.x.neg   <= neg_x_s3;
			din_s4.y.mag   <= ppts_pkg::MAG_W'(abs_y_s3) * ppts_pkg::MAG_W'(vp_h_q);
			din_s4.y.neg   <= neg_y_s3;
			din_s4.cw      <= cw_s3;
			din_s4.tag.behind <= behind_s3;
			din_s4.tag.bx  <= ppts_pkg::BEHIND_W'(clamp_x_s3) *
				ppts_pkg::BEHIND_W'(ppts_pkg::BEHIND_SCALE);
			din_s4.tag.by  <= ppts_pkg::BEHIND_W'(clamp_y_s3) *
				ppts_pkg::BEHIND_W'(ppts_pkg::BEHIND_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= vld_clip;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Divide both scaled coordinates by w
	ppts_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (vld_s4),
		.din     (din_s4),
		.rdy_nxt (rdy_s22),
		.rdy     (rdy_div),
		.vld_out (vld_div),
		.dout    (dout)
	);

	// Map to pixels around the viewport center, y flipped
	assign base_x = $signed({{(ppts_pkg::RES_W - ppts_pkg::VP_W - ppts_pkg::PIX_SHIFT){1'b0}},
		vp_w_q, {ppts_pkg::PIX_SHIFT{1'b0}}});
	assign base_y = $signed({{(ppts_pkg::RES_W - ppts_pkg::VP_W - ppts_pkg::PIX_SHIFT){1'b0}},
		vp_h_q, {ppts_pkg::PIX_SHIFT{1'b0}}});
	assign res_x  = base_x + signed_quot(dout.x);
	assign res_y  = base_y - signed_quot(dout.y);

	// Output register: hold while stalled
	assign rdy_s22 = !vld_s22 || !screen_stall;

	always_ff @(posedge clk) begin
		if (rdy_s22) begin
			if (dout.tag.behind) begin
				screen_s22.pixel_x <= ppts_pkg::sat32(ppts_pkg::SUM_W'(dout.tag.bx));
				screen_s22.pixel_y <= ppts_pkg::sat32(ppts_pkg::SUM_W'(dout.tag.by));
			end else begin
				screen_s22.pixel_x <= ppts_pkg::sat32(ppts_pkg::SUM_W'(res_x));
				screen_s22.pixel_y <= ppts_pkg::sat32(ppts_pkg::SUM_W'(res_y));
			end
			screen_s22.in_front <= !dout.tag.behind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s22 <= 1'b0;
		end else if (rdy_s22) begin
			vld_s22 <= vld_div;
		end
	end

	assign screen_valid = vld_s22;
	assign screen       = screen_s22;

endmodule

`default_nettype wire

// File: rtl/ppts_checker.sv
// Port-level checks for the projection pipeline and their binding to the top level.
`default_nettype none

module ppts_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           point_valid,
	input wire logic                           point_stall,
	input wire ppts_pkg::point_t               point,
	input wire logic                           screen_valid,
	input wire logic                           screen_stall,
	input wire ppts_pkg::screen_t              screen,
	input wire logic                           cfg_we,
	input wire logic [ppts_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [ppts_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned CNT_W = $clog2(ppts_pkg::PIPE_DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc;
	logic             out_acc;
	logic             unused_ok;

	assign in_acc    = point_valid && !point_stall;
	assign out_acc   = screen_valid && !screen_stall;
	assign unused_ok = ^{point, cfg_we, cfg_index, cfg_data};

	// Track requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && screen_stall |=> screen_valid && $stable(screen))
		else $error("stalled result changed or dropped");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ppts_pkg::PIPE_DEPTH) || unused_ok != unused_ok)
		else $error("more requests in flight than pipeline stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid |-> cnt_q != '0)
		else $error("result shown with no request in flight");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> screen_valid && screen_stall &&
			cnt_q == CNT_W'(ppts_pkg::PIPE_DEPTH))
		else $error("input stalled while the pipeline has room");

endmodule

bind perspective_project_to_screen_top ppts_checker u_ppts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point_valid),
	.point_stall  (point_stall),
	.point        (point),
	.screen_valid (screen_valid),
	.screen_stall (screen_stall),
	.screen       (screen),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

`default_nettype wire

// File: tb/sv/perspective_project_to_screen_top_tb.sv
// Self-checking testbench for the perspective projection block: predicted screen requests vs DUT.
`timescale 1ns / 1ps

module perspective_project_to_screen_top_tb;
	import ppts_pkg::*;

	localparam longint WORD_MAX  = 2147483647;
	localparam longint WORD_MIN  = -WORD_MAX - 1;
	localparam longint PIX_UNIT  = 64'sd1 << PIX_SHIFT;
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
	localparam logic [31:0] MINW = 32'h8000_0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 point_valid = 1'b0;
	logic                 point_stall;
	point_t               point = '0;
	logic                 screen_valid;
	logic                 screen_stall = 1'b0;
	screen_t              screen;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Predictor copy of the register file
	mat_t            mat_words = '0;
	logic [VP_W-1:0] vp_width = VP_WIDTH_RST;
	logic [VP_W-1:0] vp_height = VP_HEIGHT_RST;

	point_t  point_queue [$];
	screen_t screen_due [$];
	logic    point_taken = 1'b0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      err_count = 0;
	int      points_in = 0;
	int      front_count = 0;
	int      behind_count = 0;
	int      settings_count = 0;
	logic [CFG_W-1:0] setting [8];

	perspective_project_to_screen_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.screen_valid(screen_valid),
		.screen_stall(screen_stall),
		.screen      (screen),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint clamp_word(longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	// Dot product of one matrix row with (x, y, z, 1); each product floored to Q16.16
	function automatic longint clip_dot(int row, point_t p);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		longint acc;
		lo = mat_words[2*row];
		hi = mat_words[2*row+1];
		acc = (longint'($signed(lo[31:0])) * longint'(p.world_x)) >>> PROD_SHIFT;
		acc += (longint'($signed(lo[63:32])) * longint'(p.world_y)) >>> PROD_SHIFT;
		acc += (longint'($signed(hi[31:0])) * longint'(p.world_z)) >>> PROD_SHIFT;
		acc += longint'($signed(hi[63:32]));
		return clamp_word(acc);
	endfunction

	function automatic logic [31:0] behind_pixel(longint c);
		longint lim;
		lim = longint'(BEHIND_CLAMP);
		if (c > lim) c = lim;
		if (c < -lim) c = -lim;
		return 32'(clamp_word(c * longint'(BEHIND_SCALE)));
	endfunction

	function automatic screen_t project_point(point_t p);
		longint cx, cy, cw, wd, ht;
		screen_t s;
		cx = clip_dot(0, p);
		cy = clip_dot(1, p);
		cw = clip_dot(2, p);
		if (cw < longint'(BEHIND_W_RAW)) begin
			s.pixel_x  = behind_pixel(cx);
			s.pixel_y  = behind_pixel(cy);
			s.in_front = 1'b0;
		end else begin
			wd = longint'(vp_width);
			ht = longint'(vp_height);
			s.pixel_x  = 32'(clamp_word(wd * PIX_UNIT + (cx * wd * PIX_UNIT) / cw));
			s.pixel_y  = 32'(clamp_word(ht * PIX_UNIT - (cy * ht * PIX_UNIT) / cw));
			s.in_front = 1'b1;
		end
		return s;
	endfunction

	function automatic logic [31:0] rand_q(int unsigned span);
		return 32'($urandom_range(2 * span) - span);
	endfunction

	// Track register writes and predict each accepted point
	always @(posedge clk) begin
		point_taken <= point_valid && !point_stall;
		if (arst_n && cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VP_WIDTH: vp_width <= cfg_data[VP_W-1:0];
				REG_VP_HEIGHT: vp_height <= cfg_data[VP_W-1:0];
				default: mat_words[cfg_index] <= cfg_data;
			endcase
		end
		if (arst_n && point_valid && !point_stall) begin
			screen_due.push_back(project_point(point));
			points_in++;
		end
	end

	// Present pending points; hold a stalled request unchanged
	always @(negedge clk) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else if (point_valid && !point_taken) begin
			point_valid <= 1'b1;
		end else if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			point       <= point_queue.pop_front();
			point_valid <= 1'b1;
		end else begin
			point_valid <= 1'b0;
		end
	end

	// Stall the output at random
	always @(negedge clk) begin
		screen_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each accepted screen request with the oldest prediction
	always @(posedge clk) begin
		screen_t want;
		if (arst_n && screen_valid && !screen_stall) begin
			if (screen_due.size() == 0) begin
				if (err_count < 10)
					$display("unexpected screen request x=%h y=%h front=%b",
						screen.pixel_x, screen.pixel_y, screen.in_front);
				err_count++;
			end else begin
				want = screen_due.pop_front();
				if (want.in_front) front_count++;
				else behind_count++;
				if (screen.pixel_x !== want.pixel_x || screen.pixel_y !== want.pixel_y ||
						screen.in_front !== want.in_front) begin
					if (err_count < 10)
						$display("mismatch at %0t: expected x=%h y=%h front=%b, got x=%h y=%h front=%b",
							$realtime, want.pixel_x, want.pixel_y, want.in_front,
							screen.pixel_x, screen.pixel_y, screen.in_front);
					err_count++;
				end
			end
		end
	end

	task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.world_x = x;
		p.world_y = y;
		p.world_z = z;
		point_queue.push_back(p);
	endtask

	// Wait until every request is through, then let the pipeline settle
	task automatic drain();
		do @(negedge clk);
		while (point_queue.size() != 0 || point_valid || screen_due.size() != 0);
		repeat (PIPE_DEPTH + 8) @(negedge clk);
	endtask

	task automatic apply_settings();
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= setting[i];
			@(negedge clk);
			cfg_we    <= 1'b0;
		end
		settings_count++;
	endtask

	initial begin
		int unsigned pick;
		logic [VP_W-1:0] vp;
		logic wild;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero matrix puts every point behind at the origin
		add_point(32'h0, 32'h0, 32'h0);
		add_point(MAXW, MINW, MAXW);
		drain();

		// Unit rows with w = z; widest and narrowest viewport
		setting[0] = {32'h0, ONE};
		setting[1] = '0;
		setting[2] = {ONE, 32'h0};
		setting[3] = '0;
		setting[4] = '0;
		setting[5] = {32'h0, ONE};
		setting[6] = 64'd8192;
		setting[7] = 64'd1;
		apply_settings();
		add_point(32'h0, 32'h0, ONE);
		add_point(ONE, -ONE, 2 * ONE);
		add_point(MAXW, MINW, 32'd66);
		add_point(32'd1, 32'd1, 32'd65);
		add_point(32'd1, -32'd1, 32'd67);
		add_point(MAXW, MINW, -ONE);
		add_point(32'd21474, -32'd21474, 32'h0);
		add_point(-32'd1, -32'd1, MAXW);
		add_point(MINW, MAXW, MAXW);
		drain();

		// Zero width and a height beyond the nominal range, junk in upper bits
		setting[6] = 64'hFFFF_FFFF_FFFF_C000;
		setting[7] = 64'hA5A5_0000_0000_3FFF;
		apply_settings();
		add_point(ONE, ONE, ONE);
		add_point(-ONE, -ONE, 4 * ONE);
		add_point(MAXW, MAXW, 32'd66);
		drain();

		// Extreme coefficients drive clip x, y and w into saturation
		setting[0] = {MAXW, MAXW};
		setting[1] = {MAXW, MAXW};
		setting[2] = {MINW, MINW};
		setting[3] = {MINW, MINW};
		setting[4] = {MAXW, MAXW};
		setting[5] = {MAXW, MAXW};
		setting[6] = 64'd1920;
		setting[7] = 64'd1080;
		apply_settings();
		add_point(MAXW, MAXW, MAXW);
		add_point(MINW, MINW, MINW);
		add_point(32'd1, 32'd1, 32'd1);
		add_point(MINW, MAXW, 32'h0);
		drain();

		// Random phases: fresh settings each time, idling mode rotates
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 82; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 82; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			wild = (ph == 5) || (ph == 7);
			for (int i = 0; i < 4; i++)
				setting[i] = wild ? {$urandom(), $urandom()} :
					{rand_q(4 << 16), rand_q(4 << 16)};
			if (wild) begin
				setting[4] = {$urandom(), $urandom()};
				setting[5] = {$urandom(), $urandom()};
			end else begin
				// keep w mostly tied to z so both sides of the viewer show up
				setting[4] = {rand_q(1 << 16), rand_q(1 << 16)};
				setting[5] = {rand_q(2 << 16), 32'($urandom_range(2 << 16))};
			end
			for (int i = 6; i < 8; i++) begin
				pick = $urandom_range(11);
				case (pick)
					0: vp = 14'd1;
					1: vp = 14'd8192;
					2: vp = 14'd0;
					3: vp = 14'd16383;
					default: vp = 14'($urandom_range(8192, 1));
				endcase
				setting[i] = ({$urandom(), $urandom()} & ~64'h3FFF) | 64'(vp);
			end
			apply_settings();
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(99) < 15)
					add_point($urandom(), $urandom(), $urandom());
				else
					add_point(rand_q(16 << 16), rand_q(16 << 16), rand_q(16 << 16));
			end
			drain();
		end

		$display("Projected %0d points over %0d register settings: %0d in front, %0d behind",
			points_in, settings_count, front_count, behind_count);
		$display("Idling covered: none, sender gaps, output stalls, and both together");
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatching screen requests", err_count);
			$display("FAIL");
		end
		$finish;
	end

	// Hard limit on run time
	initial begin
		#400_000;
		$display("timeout with %0d screen requests outstanding", screen_due.size());
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/ppts_pkg.sv
rtl/ppts_clip.sv
rtl/ppts_div.sv
rtl/perspective_project_to_screen_top.sv
rtl/ppts_checker.sv
tb/sv/perspective_project_to_screen_top_tb.sv
